// ===== sv/skvn_pkg.sv =====
// Package for the sorted key/value node: sizes, operation codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package skvn_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 144;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_UPDATE    = 3'd2,
        OP_FIND      = 3'd3,
        OP_READ_AT   = 3'd4,
        OP_READ_NEXT = 3'd5,
        OP_BAD6      = 3'd6,
        OP_BAD7      = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FIRST,
        S_RD,
        S_EXEC,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic first;
        logic rd;
        logic exec;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic loop;
        logic more;
    } t_stat;

endpackage

// ===== sv/skvn_ctrl.sv =====
// Controller FSM for the sorted key/value node: sequences each item through
// its phases. Depends on skvn_pkg.
module skvn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  skvn_pkg::t_stat i_stat,
    output skvn_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);
    import skvn_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_stat.ok ? S_FIRST : S_DONE;
            end
            S_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = i_stat.loop ? S_RD : S_FIN;
            end
            S_RD: begin
                if (i_stat.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EXEC;
                end else begin
                    n_state  = S_FIN;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/skvn_dp.sv =====
// Datapath for the sorted key/value node: pair memory, count, item and result
// registers, shift and search steps. Depends on skvn_pkg.
module skvn_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    input  skvn_pkg::t_cmd            i_cmd,
    input  logic [skvn_pkg::IN_W-1:0] i_item,
    output skvn_pkg::t_stat           o_stat,
    output logic [skvn_pkg::OUT_W-1:0] o_result
);
    import skvn_pkg::*;

    logic [KEY_W+VAL_W-1:0] r_mem [CAPACITY];
    logic [KEY_W+VAL_W-1:0] r_rd;

    t_op              r_op;
    logic [CNT_W-1:0] r_pos, r_ptr, r_cnt, r_found;
    logic [KEY_W-1:0] r_key, r_kout;
    logic [VAL_W-1:0] r_val, r_vout;
    logic             r_uk, r_uv, r_ro, r_hit, r_exact, r_status;
    logic [ADDR_W-1:0] r_idx;

    logic [CNT_W-1:0]  w_pos1, w_ra;
    logic [CNT_W:0]    w_pos1_wide;
    logic [ADDR_W-1:0] w_wa;
    logic [KEY_W+VAL_W-1:0] w_wd;
    logic              w_we;
    logic [KEY_W-1:0]  w_rkey;
    logic [VAL_W-1:0]  w_rval;

    assign w_rkey      = r_rd[KEY_W-1:0];
    assign w_rval      = r_rd[KEY_W+VAL_W-1:KEY_W];
    assign w_pos1_wide = {1'b0, r_pos} + (CNT_W+1)'(1);
    assign w_pos1      = w_pos1_wide[CNT_W-1:0];

    always_comb begin
        o_stat.ok = 1'b0;
        unique case (r_op)
            OP_INSERT:    o_stat.ok = !r_ro && r_pos <= r_cnt && r_cnt < CNT_W'(CAPACITY);
            OP_REMOVE,
            OP_UPDATE:    o_stat.ok = !r_ro && r_pos < r_cnt;
            OP_FIND:      o_stat.ok = 1'b1;
            OP_READ_AT:   o_stat.ok = r_pos < r_cnt;
            OP_READ_NEXT: o_stat.ok = w_pos1_wide < {1'b0, r_cnt};
            default:      o_stat.ok = 1'b0;
        endcase
        o_stat.loop = r_op == OP_INSERT || r_op == OP_REMOVE || r_op == OP_FIND;
        o_stat.more = 1'b0;
        w_ra        = r_ptr;
        unique case (r_op)
            OP_INSERT: begin
                o_stat.more = r_ptr > r_pos;
                w_ra        = r_ptr - CNT_W'(1);
            end
            OP_REMOVE: begin
                o_stat.more = (r_ptr + CNT_W'(1)) < r_cnt;
                w_ra        = r_ptr + CNT_W'(1);
            end
            OP_FIND: begin
                o_stat.more = r_ptr < r_cnt;
                w_ra        = r_ptr;
            end
            default: w_ra = r_ptr;
        endcase
        if (i_cmd.start) w_ra = (r_op == OP_READ_NEXT) ? w_pos1 : r_pos;
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = r_ptr[ADDR_W-1:0];
        w_wd = r_rd;
        if (i_cmd.first && r_op == OP_UPDATE) begin
            w_we = 1'b1;
            w_wa = r_pos[ADDR_W-1:0];
            w_wd = {r_uv ? r_val : w_rval, r_uk ? r_key : w_rkey};
        end else if (i_cmd.exec && (r_op == OP_INSERT || r_op == OP_REMOVE)) begin
            w_we = 1'b1;
        end else if (i_cmd.fin && r_op == OP_INSERT) begin
            w_we = 1'b1;
            w_wa = r_pos[ADDR_W-1:0];
            w_wd = {r_val, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ro  <= 1'b0;
        end else begin
            if (i_cfg_we) r_ro <= i_cfg_wdata;
            if (i_cmd.fin && r_op == OP_INSERT) r_cnt <= r_cnt + CNT_W'(1);
            if (i_cmd.fin && r_op == OP_REMOVE) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_item[2:0]);
            r_pos <= i_item[9:3];
            r_key <= i_item[73:10];
            r_val <= i_item[137:74];
            r_uk  <= i_item[138];
            r_uv  <= i_item[139];
        end
        if (i_cmd.start) begin
            r_status <= !o_stat.ok;
            r_found  <= '0;
            r_exact  <= 1'b0;
            r_kout   <= '0;
            r_vout   <= '0;
            r_hit    <= 1'b0;
            r_idx    <= '0;
            unique case (r_op)
                OP_INSERT: r_ptr <= r_cnt;
                OP_REMOVE: r_ptr <= r_pos;
                default:   r_ptr <= '0;
            endcase
        end
        if (i_cmd.first && (r_op == OP_REMOVE || r_op == OP_READ_AT
                            || r_op == OP_READ_NEXT)) begin
            r_kout <= w_rkey;
            r_vout <= w_rval;
        end
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_INSERT: r_ptr <= r_ptr - CNT_W'(1);
                OP_REMOVE: r_ptr <= r_ptr + CNT_W'(1);
                OP_FIND: begin
                    r_ptr <= r_ptr + CNT_W'(1);
                    if (w_rkey <= r_key) begin
                        r_hit   <= 1'b1;
                        r_idx   <= r_ptr[ADDR_W-1:0];
                        r_exact <= w_rkey == r_key;
                    end
                end
                default: r_ptr <= r_ptr;
            endcase
        end
        if (i_cmd.fin && r_op == OP_FIND) begin
            r_found <= r_hit ? CNT_W'(r_idx) : '1;
        end
    end

    assign o_result = {r_cnt, r_vout, r_kout, r_exact, r_found, r_status};

endmodule

// ===== sv/sorted_key_value_node_top.sv =====
// Sorted key/value node top level: stream ports, controller and datapath.
// A successful update or read passes the states start, first, fin and done; a failed item
// goes from start to done; insert, remove and find add an rd/exec pair of states per pair
// shifted or key scanned, and a last rd, walking the pair memory one pair per step. One item
// at a time: a new item is taken only in idle, after the result is accepted, so output wait holds input.
// Reset (synchronous, active low) clears the count, read-only and the FSM; memory is not cleared.
module sorted_key_value_node_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // operation, position, key_in, value_in, key write flag, value write flag, pad
    input  logic [skvn_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // status, found_index, exact_match, key_out, value_out, entry_count_out
    output logic [skvn_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import skvn_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    skvn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid)
    );

    skvn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_item      (i_s_axis_tdata),
        .o_stat      (w_stat),
        .o_result    (o_m_axis_tdata)
    );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for sorted_key_value_node_top: drives operations on the stream input,
// predicts every result with a local copy of the node, compares field by field.
// Depends on skvn_pkg and the DUT only.
module tb_top;
    import skvn_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    sorted_key_value_node_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata)
    );

    typedef struct packed {
        logic [6:0]  entry_count;
        logic [63:0] value;
        logic [63:0] key;
        logic        exact;
        logic [6:0]  found;
        logic        status;
    } t_node_result;

    // node mirror
    logic [63:0]    key_mirror [CAPACITY];
    logic [63:0]    val_mirror [CAPACITY];
    int unsigned    pair_count;
    logic           ro_mirror;

    t_node_result   pending_results [$];
    int             mismatches;
    longint         cycles;
    bit             checking_on;
    bit             quiet_rx;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_node_result predict_node(t_op op, logic [6:0] pos, logic [63:0] k,
                                                  logic [63:0] v, logic uk, logic uv);
        t_node_result r;
        int i;
        bit hit;
        int idx;
        r = '0;
        r.status = 1'b1;
        case (op)
            OP_INSERT: if (!ro_mirror && pos <= pair_count && pair_count < CAPACITY) begin
                for (i = pair_count; i > pos; i--) begin
                    key_mirror[i] = key_mirror[i-1];
                    val_mirror[i] = val_mirror[i-1];
                end
                key_mirror[pos] = k;
                val_mirror[pos] = v;
                pair_count++;
                r.status = 1'b0;
            end
            OP_REMOVE: if (!ro_mirror && pos < pair_count) begin
                r.key = key_mirror[pos];
                r.value = val_mirror[pos];
                pair_count--;
                for (i = pos; i < pair_count; i++) begin
                    key_mirror[i] = key_mirror[i+1];
                    val_mirror[i] = val_mirror[i+1];
                end
                r.status = 1'b0;
            end
            OP_UPDATE: if (!ro_mirror && pos < pair_count) begin
                if (uk) key_mirror[pos] = k;
                if (uv) val_mirror[pos] = v;
                r.status = 1'b0;
            end
            OP_FIND: begin
                hit = 0;
                idx = 0;
                for (i = 0; i < pair_count; i++)
                    if (key_mirror[i] <= k) begin
                        hit = 1;
                        idx = i;
                    end
                if (hit) begin
                    r.found = idx[6:0];
                    r.exact = (key_mirror[idx] == k);
                end else begin
                    r.found = 7'h7F;
                end
                r.status = 1'b0;
            end
            OP_READ_AT: if (pos < pair_count) begin
                r.key = key_mirror[pos];
                r.value = val_mirror[pos];
                r.status = 1'b0;
            end
            OP_READ_NEXT: if (pos + 1 < pair_count) begin
                r.key = key_mirror[pos+1];
                r.value = val_mirror[pos+1];
                r.status = 1'b0;
            end
            default: ;
        endcase
        r.entry_count = pair_count[6:0];
        return r;
    endfunction

    task automatic send_item(t_op op, logic [6:0] pos, logic [63:0] k, logic [63:0] v,
                             logic uk, logic uv, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        s_tdata = {4'd0, uv, uk, v, k, pos, op};
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_node(op, pos, k, v, uk, uv));
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // receiver: per result, a random wait before ready, none when quiet_rx is set
    initial begin : rx_driver
        int rx_gap;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (m_tvalid) begin
                rx_gap = quiet_rx ? 0 : $urandom_range(0, 15);
                repeat (rx_gap) @(negedge i_clk);
                m_tready = 1'b1;
                @(posedge i_clk);
                @(negedge i_clk);
                m_tready = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_node_result got, want;
        if (checking_on && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.exact !== want.exact || got.key !== want.key ||
                    got.value !== want.value || got.entry_count !== want.entry_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: st %b/%b fi %h/%h ex %b/%b k %h/%h v %h/%h n %0d/%0d",
                                 want.status, got.status, want.found, got.found,
                                 want.exact, got.exact, want.key, got.key,
                                 want.value, got.value, want.entry_count, got.entry_count);
                end
            end
        end
    end

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_ro_reg(logic ro);
        drain_results();
        i_cfg_wdata <= ro;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ro_mirror = ro;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // key near existing entries (or random) so finds hit exactly or in between
    function automatic logic [63:0] nearby_key();
        int i;
        if (pair_count == 0 || $urandom_range(0, 3) == 0) return rand64();
        i = $urandom_range(0, pair_count - 1);
        case ($urandom_range(0, 2))
            0: return key_mirror[i];
            1: return key_mirror[i] + 1;
            default: return key_mirror[i] - 1;
        endcase
    endfunction

    // sorted position for a key
    function automatic logic [6:0] sorted_slot(logic [63:0] k);
        int i;
        for (i = 0; i < pair_count; i++)
            if (key_mirror[i] > k) return i[6:0];
        return pair_count[6:0];
    endfunction

    task automatic test_directed_ops();
        send_item(OP_FIND, 7'd0, 64'd5, 64'd0, 0, 0);
        send_item(OP_READ_AT, 7'd0, 64'd0, 64'd0, 0, 0);
        send_item(OP_REMOVE, 7'd0, 64'd0, 64'd0, 0, 0);
        send_item(OP_INSERT, 7'd1, 64'd1, 64'd1, 0, 0);
        send_item(OP_INSERT, 7'd0, 64'd0, '1, 0, 0);
        send_item(OP_INSERT, 7'd1, '1, 64'd0, 0, 0);
        send_item(OP_INSERT, 7'd1, 64'h8000_0000_0000_0000, 64'h5555, 0, 0);
        send_item(OP_FIND, 7'd0, '1, 64'd0, 0, 0);
        send_item(OP_FIND, 7'd0, 64'h8000_0000_0000_0000, 64'd0, 0, 0);
        send_item(OP_FIND, 7'd0, 64'd0, 64'd0, 0, 0);
        send_item(OP_UPDATE, 7'd1, 64'd7, 64'd9, 0, 0);
        send_item(OP_UPDATE, 7'd1, 64'd7, 64'd9, 1, 0);
        send_item(OP_UPDATE, 7'd1, 64'd7, '1, 0, 1);
        send_item(OP_UPDATE, 7'd2, 64'd0, 64'd3, 1, 1);
        send_item(OP_FIND, 7'd0, 64'd7, 64'd0, 0, 0);
        send_item(OP_READ_NEXT, 7'd1, 64'd0, 64'd0, 0, 0);
        send_item(OP_READ_NEXT, 7'd2, 64'd0, 64'd0, 0, 0);
        send_item(OP_READ_AT, 7'd127, 64'd0, 64'd0, 0, 0);
        send_item(OP_READ_NEXT, 7'd127, 64'd0, 64'd0, 0, 0);
        send_item(OP_BAD6, 7'd0, 64'd0, 64'd0, 1, 1);
        send_item(OP_BAD7, 7'd127, '1, '1, 1, 1);
        send_item(OP_REMOVE, 7'd2, 64'd0, 64'd0, 0, 0);
        send_item(OP_REMOVE, 7'd3, 64'd0, 64'd0, 0, 0);
        send_item(OP_REMOVE, 7'd0, 64'd0, 64'd0, 0, 0);
    endtask

    task automatic test_read_only();
        write_ro_reg(1'b1);
        send_item(OP_INSERT, 7'd0, 64'd4, 64'd4, 0, 0);
        send_item(OP_REMOVE, 7'd0, 64'd0, 64'd0, 0, 0);
        send_item(OP_UPDATE, 7'd0, 64'd1, 64'd1, 1, 1);
        send_item(OP_READ_AT, 7'd0, 64'd0, 64'd0, 0, 0);
        send_item(OP_FIND, 7'd0, '1, 64'd0, 0, 0);
        write_ro_reg(1'b0);
    endtask

    task automatic test_fill_to_capacity();
        int i;
        logic [63:0] k;
        while (pair_count < CAPACITY) begin
            k = rand64();
            send_item(OP_INSERT, sorted_slot(k), k, rand64(), 0, 0, 0);
        end
        send_item(OP_INSERT, 7'd0, 64'd1, 64'd1, 0, 0);
        send_item(OP_INSERT, 7'd64, 64'd1, 64'd1, 0, 0);
        send_item(OP_READ_AT, 7'd63, 64'd0, 64'd0, 0, 0);
        send_item(OP_READ_NEXT, 7'd62, 64'd0, 64'd0, 0, 0);
        send_item(OP_READ_NEXT, 7'd63, 64'd0, 64'd0, 0, 0);
        send_item(OP_FIND, 7'd0, '1, 64'd0, 0, 0);
        write_ro_reg(1'b1);
        send_item(OP_REMOVE, 7'd63, 64'd0, 64'd0, 0, 0);
        write_ro_reg(1'b0);
        for (i = 0; i < 50; i++)
            send_item(OP_REMOVE, 7'($urandom_range(0, pair_count)), 64'd0, 64'd0, 0, 0, 0);
    endtask

    task automatic test_random_mix(int count);
        int n;
        int sel;
        logic [63:0] k;
        logic [6:0] pos;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel == 0) write_ro_reg(1'($urandom_range(0, 1)));
            pos = (pair_count == 0) ? 7'd0 : 7'($urandom_range(0, pair_count - 1));
            if ($urandom_range(0, 9) == 0) pos = 7'($urandom());
            if (sel < 30 && pair_count < 40) begin
                k = nearby_key();
                if ($urandom_range(0, 9) != 0) pos = sorted_slot(k);
                send_item(OP_INSERT, pos, k, rand64(), 0, 0);
            end else if (sel < 45) begin
                send_item(OP_REMOVE, pos, 64'd0, 64'd0, 0, 0);
            end else if (sel < 55) begin
                send_item(OP_UPDATE, pos, nearby_key(), rand64(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (sel < 80) begin
                send_item(OP_FIND, pos, nearby_key(), rand64(), 0, 0);
            end else if (sel < 88) begin
                send_item(OP_READ_AT, pos, rand64(), 64'd0, 0, 0);
            end else if (sel < 96) begin
                send_item(OP_READ_NEXT, pos, rand64(), 64'd0, 0, 0);
            end else begin
                send_item(t_op'($urandom_range(6, 7)), 7'($urandom()), rand64(), rand64(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cycles = 0;
        mismatches = 0;
        checking_on = 0;
        quiet_rx = 0;
        pair_count = 0;
        ro_mirror = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        checking_on = 1;
        @(negedge i_clk);
        test_directed_ops();
        test_read_only();
        test_fill_to_capacity();
        test_random_mix(450);
        quiet_rx = 1;
        test_random_mix(150);
        quiet_rx = 0;
        write_ro_reg(1'b0);
        drain_results();
        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
